// ===== rtl/lehs_pkg.sv =====
// ============================================================================
// lehs_pkg - shared types and constants for the LSB header search block
// Token word passed from the bit packer to the header matcher, the header
// pattern function and the default sizes.
// ============================================================================
package lehs_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned HEADER_LEN_DEF  = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam logic [BYTE_W-1:0] PATTERN_TOP = 8'hFF;
    localparam logic [2:0]        LAST_BIT_POS = 3'd7;

    // One packed byte on its way to the window; last marks end of data.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } lehs_token_t;

    // Header byte j, oldest first: 0xFF, 0xFE, ...
    function automatic logic [BYTE_W-1:0] hdr_pattern(input int unsigned j);
        logic [BYTE_W-1:0] jb;
        jb = BYTE_W'(j);
        return PATTERN_TOP - jb;
    endfunction

endpackage

// ===== rtl/lehs_front.sv =====
// ============================================================================
// lehs_front - carrier bit packer
// Collects bit 0 of each carrier byte, LSB first, and emits a token for each
// completed byte or for the partial byte at end of data.
// ============================================================================
module lehs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           carrier_byte,
    input  logic                 end_of_data,
    input  logic                 q_ready,
    output logic                 tok_valid,
    output lehs_pkg::lehs_token_t tok
);
    import lehs_pkg::*;

    logic [BYTE_W-1:0] partial_reg, partial_next;
    logic [2:0]        bitpos_reg, bitpos_next;
    logic [BYTE_W-1:0] assembled;
    logic              accept;
    logic              emit;

    assign in_ready  = q_ready;
    assign accept    = in_valid && q_ready;
    assign assembled = partial_reg | ({{(BYTE_W-1){1'b0}}, carrier_byte[0]} << bitpos_reg);
    assign emit      = (bitpos_reg == LAST_BIT_POS) || end_of_data;

    assign tok_valid = accept && emit;
    assign tok.data  = assembled;
    assign tok.last  = end_of_data;

    always_comb
    begin
        partial_next = partial_reg;
        bitpos_next  = bitpos_reg;
        if (accept)
        begin
            if (emit)
            begin
                partial_next = '0;
                bitpos_next  = '0;
            end
            else
            begin
                partial_next = assembled;
                bitpos_next  = bitpos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            bitpos_reg  <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            bitpos_reg  <= bitpos_next;
        end
    end

endmodule

// ===== rtl/lehs_queue.sv =====
// ============================================================================
// lehs_queue - short token queue
// Register-based FIFO between the packer and the matcher.
// ============================================================================
module lehs_queue #(
    parameter int unsigned DEPTH = lehs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  lehs_pkg::lehs_token_t wr_tok,
    output logic                  not_full,
    output logic                  rd_valid,
    input  logic                  rd_en,
    output lehs_pkg::lehs_token_t rd_tok
);
    import lehs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lehs_token_t      entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign not_full = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_tok   = entries[rd_ptr_reg];
    assign do_wr    = wr_en && not_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries[wr_ptr_reg] <= wr_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/lehs_back.sv =====
// ============================================================================
// lehs_back - header window and matcher
// Shifts packed bytes into the window, compares with the header pattern,
// counts packed bytes and holds the result word in an output register.
// ============================================================================
module lehs_back #(
    parameter int unsigned HEADER_LEN = lehs_pkg::HEADER_LEN_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tok_valid,
    input  lehs_pkg::lehs_token_t  tok,
    output logic                   tok_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   header_found,
    output logic [31:0]            header_end_offset
);
    import lehs_pkg::*;

    localparam int unsigned FILL_W = $clog2(HEADER_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HEADER_LEN);

    logic [BYTE_W-1:0]  window_reg [HEADER_LEN];
    logic [BYTE_W-1:0]  window_next [HEADER_LEN];
    logic [FILL_W-1:0]  fill_reg, fill_next, fill_after;
    logic [COUNT_W-1:0] count_reg, count_next, count_after;
    logic               done_reg, done_next;
    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;
    logic [COUNT_W-1:0] offset_reg, offset_next;
    logic               hit;
    logic               slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign tok_pop   = tok_valid && slot_free;

    // Window after shifting in the token byte
    always_comb
    begin
        for (int unsigned i = 0; i + 1 < HEADER_LEN; i++)
            window_next[i] = window_reg[i + 1];
        window_next[HEADER_LEN - 1] = tok.data;
    end

    assign fill_after  = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
    assign count_after = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        hit = (fill_after == FILL_FULL);
        for (int unsigned j = 0; j < HEADER_LEN; j++)
            if (window_next[j] != hdr_pattern(j))
                hit = 1'b0;
    end

    always_comb
    begin
        fill_next      = fill_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        found_next     = found_reg;
        offset_next    = offset_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (tok_pop)
        begin
            if (done_reg)
            begin
                // Search over: ignore words until end of data
                if (tok.last)
                begin
                    fill_next  = '0;
                    count_next = '0;
                    done_next  = 1'b0;
                end
            end
            else
            begin
                fill_next  = fill_after;
                count_next = count_after;
                if (hit)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    offset_next    = count_after;
                    done_next      = !tok.last;
                end
                else if (tok.last)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    offset_next    = '0;
                end
                if (tok.last)
                begin
                    fill_next  = '0;
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && !done_reg)
            window_reg <= window_next;
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign header_found      = found_reg;
    assign header_end_offset = offset_reg;

endmodule

// ===== rtl/lsb_extract_header_search.sv =====
// ============================================================================
// lsb_extract_header_search - LSB payload extraction with sync header search
// Packs carrier LSBs into bytes and searches them for the 0xFF,0xFE,... header.
// ============================================================================
// One carrier word is taken every clock cycle for as long as the output side
// keeps up. Bit 0 of each carrier byte is packed LSB first; each full packed
// byte, or the partial byte at end_of_data, enters a window of HEADER_LEN
// bytes that is compared with 0xFF, 0xFE, ... (oldest byte first). The first
// match gives one result word: header_found = 1 and header_end_offset = the
// packed-byte count up to and including the last header byte (saturating at
// 0xFFFFFFFF). If end_of_data arrives with no match, the result word is
// header_found = 0 with offset 0. After a match, words are ignored until
// end_of_data, which gives no result. The packer, window fill, byte count and
// match state clear at end of data. Throughput is one word per cycle while
// the output side keeps up, set by the combinational window compare in the
// matcher; a token passes the token queue, then the result register. A short
// token queue between packer and matcher lets each side stall on its own.
// ============================================================================
module lsb_extract_header_search #(
    parameter int unsigned HEADER_LEN  = lehs_pkg::HEADER_LEN_DEF,
    parameter int unsigned QUEUE_DEPTH = lehs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  carrier_byte,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        header_found,
    output logic [31:0] header_end_offset
);
    import lehs_pkg::*;

    // packer -> queue
    logic        q_ready;
    logic        fr_tok_valid;
    lehs_token_t fr_tok;

    // queue -> matcher
    logic        bk_tok_valid;
    logic        bk_tok_pop;
    lehs_token_t bk_tok;

    // Front: bit packing, one token per completed or final byte
    lehs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .carrier_byte (carrier_byte),
        .end_of_data  (end_of_data),
        .q_ready      (q_ready),
        .tok_valid    (fr_tok_valid),
        .tok          (fr_tok)
    );

    // Decoupling queue
    lehs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fr_tok_valid),
        .wr_tok   (fr_tok),
        .not_full (q_ready),
        .rd_valid (bk_tok_valid),
        .rd_en    (bk_tok_pop),
        .rd_tok   (bk_tok)
    );

    // Back: window shift, header compare, count and result register
    lehs_back #(
        .HEADER_LEN (HEADER_LEN)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .tok_valid         (bk_tok_valid),
        .tok               (bk_tok),
        .tok_pop           (bk_tok_pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .header_found      (header_found),
        .header_end_offset (header_end_offset)
    );

endmodule

// ===== tb/lsb_extract_header_search_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lsb_extract_header_search_test - regression for the LSB header search block
// Carrier words go in through a valid/ready channel. A behavioural model in
// this module tracks the bit packing, the header window and the match state
// for every accepted word. Each result word is checked field by field against
// the oldest prediction. A short directed table comes first. Random
// transmissions follow, built mostly around sync headers. Both channels
// idle and stall at random.
// ============================================================================
module lsb_extract_header_search_test;

    import lehs_pkg::*;

    localparam int unsigned HDR_LEN      = HEADER_LEN_DEF;
    localparam int unsigned RAND_WORDS   = 1100;     // random carrier words, roughly
    localparam int unsigned MIN_TX       = 48;       // random transmissions, at least
    localparam int unsigned LONG_HOLD    = 400;      // long receiver hold-off, cycles
    localparam int unsigned TAIL_CYCLES  = 16;       // settle time after the last result
    localparam int unsigned CYCLE_LIMIT  = 800000;
    localparam int unsigned DIR_ROWS     = 25;

    // One carrier word of stimulus. Where typed is set, found/offset give the
    // result word the block must return for it. Otherwise the model decides.
    typedef struct packed {
        logic [7:0]  cb;
        logic        eod;
        logic        typed;
        logic        found;
        logic [31:0] offset;
    } carrier_word_t;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } hdr_result_t;

    // Directed table: extremes of the carrier byte, end of data on the first
    // word, on a byte boundary, on a partial byte and just past a full byte.
    localparam carrier_word_t DIRECTED [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 1'b0, 32'd0},     // single word, bit clear
        '{8'hFF, 1'b1, 1'b1, 1'b0, 32'd0},     // single word, bit set
        '{8'hFE, 1'b1, 1'b1, 1'b0, 32'd0},
        '{8'h01, 1'b1, 1'b1, 1'b0, 32'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 32'd0},     // eight words: packed byte 0xAA
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFE, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hAA, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h55, 1'b1, 1'b1, 1'b0, 32'd0},     // end on a byte boundary
        '{8'h81, 1'b0, 1'b0, 1'b0, 32'd0},     // partial byte 0x03
        '{8'h03, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h7E, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h40, 1'b1, 1'b1, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},     // 0xFF then a one-bit partial
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{8'h01, 1'b1, 1'b1, 1'b0, 32'd0}
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  carrier_byte = 8'h00;
    logic        end_of_data  = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        header_found;
    logic [31:0] header_end_offset;

    lsb_extract_header_search #(
        .HEADER_LEN (HDR_LEN)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .carrier_byte      (carrier_byte),
        .end_of_data       (end_of_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .header_found      (header_found),
        .header_end_offset (header_end_offset)
    );

    // ------------------------------------------------------------------------
    // Clock and reset: reset held at the start, then never again
    // ------------------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------------
    carrier_word_t stim_q [$];
    hdr_result_t   results_due [$];
    int unsigned   n_sent      = 0;   // words accepted, as the sender sees it
    int unsigned   n_accepted  = 0;   // words accepted, as the monitor sees it
    int unsigned   n_tx        = 0;
    int unsigned   n_dir_tx    = 0;   // transmissions in the directed table
    int unsigned   n_found     = 0;
    int unsigned   n_missed    = 0;
    int unsigned   n_errors    = 0;
    int unsigned   cycle_count = 0;
    int unsigned   pause_mid   = 0;

    // ------------------------------------------------------------------------
    // Behavioural model of the search
    // ------------------------------------------------------------------------
    logic [7:0]  acc_byte     = '0;    // packed byte being assembled
    logic [2:0]  acc_pos      = '0;
    logic [7:0]  hdr_win [HDR_LEN];    // oldest packed byte at index 0
    int unsigned win_fill     = 0;
    logic [31:0] packed_total = '0;
    bit          hdr_locked   = 1'b0;  // header already reported

    task automatic clear_search();
        acc_byte     = '0;
        acc_pos      = '0;
        win_fill     = 0;
        packed_total = '0;
        hdr_locked   = 1'b0;
        for (int k = 0; k < HDR_LEN; k++)
            hdr_win[k] = '0;
    endtask

    // Advance the model by one accepted carrier word.
    task automatic track_header_search(input logic [7:0] cb, input logic eod,
                                       output bit has_result, output hdr_result_t res);
        bit hit;
        hit        = 1'b0;
        has_result = 1'b0;
        res        = '0;
        if (hdr_locked)
        begin
            // everything up to the next end of data is dropped silently
            if (eod)
                clear_search();
            return;
        end
        acc_byte[acc_pos] = cb[0];
        if (acc_pos == LAST_BIT_POS || eod)
        begin
            // packed byte (or the partial last one) enters the window
            for (int k = 0; k < HDR_LEN - 1; k++)
                hdr_win[k] = hdr_win[k + 1];
            hdr_win[HDR_LEN - 1] = acc_byte;
            if (win_fill < HDR_LEN)
                win_fill++;
            if (packed_total != 32'hFFFF_FFFF)
                packed_total++;
            if (win_fill == HDR_LEN)
            begin
                hit = 1'b1;
                for (int k = 0; k < HDR_LEN; k++)
                    if (hdr_win[k] != 8'(8'hFF - k))
                        hit = 1'b0;
            end
            acc_byte = '0;
            acc_pos  = '0;
        end
        else
            acc_pos++;

        if (hit)
        begin
            has_result = 1'b1;
            res.found  = 1'b1;
            res.offset = packed_total;
            if (eod)
                clear_search();
            else
                hdr_locked = 1'b1;
        end
        else if (eod)
        begin
            has_result = 1'b1;
            clear_search();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    // Payload bit in bit 0, noise in the upper seven bits.
    task automatic push_bit(input bit v);
        carrier_word_t w;
        w       = '0;
        w.cb    = {7'($urandom), v};
        stim_q.push_back(w);
    endtask

    task automatic push_rand_bits(input int unsigned n);
        repeat (n) push_bit(1'($urandom));
    endtask

    task automatic push_byte(input logic [7:0] v);
        for (int b = 0; b < 8; b++)
            push_bit(v[b]);
    endtask

    // Full sync header; one bit can be flipped to break it (flip < 0: none).
    task automatic push_header(input int flip);
        logic [7:0] hb;
        for (int j = 0; j < HDR_LEN; j++)
        begin
            hb = 8'(8'hFF - j);
            for (int b = 0; b < 8; b++)
                push_bit(hb[b] ^ (j * 8 + b == flip));
        end
    endtask

    task automatic close_transmission();
        stim_q[stim_q.size() - 1].eod = 1'b1;
        n_tx++;
    endtask

    // One random transmission. About half carry a real header somewhere, the rest
    // are plain noise, misaligned headers or headers with a flipped bit.
    task automatic add_transmission();
        int unsigned sel;
        int          flip;
        sel  = $urandom_range(0, 99);
        flip = -1;
        if (sel < 30)
            push_rand_bits($urandom_range(1, 24));
        else
        begin
            if (sel < 40)
                push_rand_bits($urandom_range(1, 7));        // off the byte grid
            else
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
            if (sel >= 40 && sel < 50)
                repeat ($urandom_range(1, 3)) push_byte(8'hFF); // window must slide
            if (sel >= 50 && sel < 60)
                flip = $urandom_range(0, HDR_LEN * 8 - 1);
            push_header(flip);
            // a quarter end on the header's last bit, so match and end coincide
            if ($urandom_range(0, 3) != 0)
                push_rand_bits($urandom_range(1, 40));
            if ($urandom_range(0, 9) == 0)
                push_header(-1);                             // ignored if the first one matched
        end
        close_transmission();
    endtask

    // ------------------------------------------------------------------------
    // Monitor: checks result words, then feeds accepted carrier words to the
    // model. Both sampled at the rising edge, before any update lands.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        hdr_result_t   got;
        hdr_result_t   want;
        hdr_result_t   res;
        bit            has_result;
        carrier_word_t w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{header_found, header_end_offset};
                if (results_due.size() == 0)
                begin
                    $error("result word with nothing expected: found %0d offset %0d",
                           got.found, got.offset);
                    n_errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("header_found: expected %0d, got %0d", want.found, got.found);
                        n_errors++;
                    end
                    if (got.offset !== want.offset)
                    begin
                        $error("header_end_offset: expected %0d, got %0d",
                               want.offset, got.offset);
                        n_errors++;
                    end
                    if (want.found)
                        n_found++;
                    else
                        n_missed++;
                end
            end
            if (in_valid && in_ready)
            begin
                w = stim_q[n_accepted];
                track_header_search(carrier_byte, end_of_data, has_result, res);
                if (w.typed)
                    results_due.push_back('{w.found, w.offset});
                else if (has_result)
                    results_due.push_back(res);
                n_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, free-running stretches, and one long hold-off
    // while the sender keeps going so the block backs up into its input.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned free_left;
        int unsigned r;
        bit          long_done;
        hold_left = 0;
        free_left = 0;
        long_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_done && n_accepted >= DIR_ROWS + 250)
            begin
                hold_left = LONG_HOLD;
                long_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (free_left != 0)
            begin
                out_ready <= 1'b1;
                free_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    free_left = $urandom_range(40, 150);
                    out_ready <= 1'b1;
                end
                else if (r < 65)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    r = $urandom_range(0, 99);
                    if (r < 88)
                        hold_left = $urandom_range(0, 2);
                    else if (r < 98)
                        hold_left = $urandom_range(3, 9);
                    else
                        hold_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender and end of run
    // ------------------------------------------------------------------------
    // Gap before the next word: mostly none, sometimes a few, rarely many.
    // A burst counter gives stretches with no gaps at all.
    int unsigned burst_left = 0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Wait until every word sent has been seen by the monitor and every
    // result it predicted has come back. Negedge keeps clear of the edge.
    task automatic wait_drained();
        while (n_accepted != n_sent || results_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : sender
        carrier_word_t w;
        int unsigned   gap;
        int unsigned   i;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            stim_q.push_back(DIRECTED[i]);
            if (DIRECTED[i].eod)
                n_dir_tx++;
        end
        while (stim_q.size() < DIR_ROWS + RAND_WORDS || n_tx < MIN_TX)
        begin
            add_transmission();
            if (pause_mid == 0 && stim_q.size() >= DIR_ROWS + RAND_WORDS / 2)
                pause_mid = stim_q.size();   // on a transmission boundary
        end

        wait (rst_n);
        @(posedge clk);
        for (i = 0; i < stim_q.size(); i++)
        begin
            // hold back after the directed part and once mid-run until drained
            if (i == DIR_ROWS || i == pause_mid)
            begin
                in_valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
            gap = pick_gap();
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            w = stim_q[i];
            in_valid     <= 1'b1;
            carrier_byte <= w.cb;
            end_of_data  <= w.eod;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            n_sent++;
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d carrier words over %0d random and %0d directed transmissions.",
                 n_sent, n_tx, n_dir_tx);
        $display("Results checked: %0d headers found, %0d not found; %0d mismatches.",
                 n_found, n_missed, n_errors);
        if (n_errors == 0)
            $display("lsb_extract_header_search regression: pass");
        else
            $display("lsb_extract_header_search regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d words sent, %0d results outstanding.",
                     cycle_count, n_sent, results_due.size());
            $display("lsb_extract_header_search regression: fail");
            $finish;
        end
    end

endmodule
